// ===== rtl/cnlf_pkg.sv =====
// Shared types, constants and helper functions of the caret notation line formatter.
package cnlf_pkg;

  localparam int unsigned MAX_COLS = 160;

  localparam logic [1:0] CMD_TEXT  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  localparam logic [1:0] REG_SCREEN_COLS = 2'd0;
  localparam logic [1:0] REG_TAB_SIZE    = 2'd1;
  localparam logic [1:0] REG_LIST_MODE   = 2'd2;
  localparam logic [1:0] REG_RAW_HIGH    = 2'd3;

  localparam logic [7:0] RST_SCREEN_COLS = 8'd80;
  localparam logic [4:0] RST_TAB_SIZE    = 5'd8;

  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_DEL       = 8'h7F;
  localparam logic [7:0] CH_DOLLAR    = 8'h24;
  localparam logic [7:0] CH_CARET     = 8'h5E;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CARET_FLIP   = 8'h40;
  localparam logic [4:0] TAB_MAX      = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MOD,
    ST_TABN,
    ST_EMIT,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic fmt;
    logic set_cursor;
    logic mod_step;
    logic tab_n;
    logic out_valid;
    logic emit_step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       is_tab;
    logic       at_limit;
    logic       list_mode;
    logic       mod_last;
    logic       out_last;
  } dp_status_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] d;
    if (v < 4'd10) begin
      d = 8'h30 + {4'd0, v};
    end else begin
      d = 8'h37 + {4'd0, v};
    end
    return d;
  endfunction

  function automatic logic [4:0] tab_eff(input logic [4:0] ts);
    logic [4:0] r;
    if (ts == 5'd0) begin
      r = 5'd1;
    end else if (ts > TAB_MAX) begin
      r = TAB_MAX;
    end else begin
      r = ts;
    end
    return r;
  endfunction

endpackage

// ===== rtl/cnlf_if.sv =====
// Input and result channel interfaces of the caret notation line formatter.
interface cnlf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] char_code;
  logic [7:0] start_col;

  modport source (output valid, cmd, char_code, start_col, input ready);
  modport sink (input valid, cmd, char_code, start_col, output ready);
endinterface

interface cnlf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [7:0] out_col;
  logic       last;

  modport source (output valid, out_char, out_col, last, input ready);
  modport sink (input valid, out_char, out_col, last, output ready);
endinterface

// ===== rtl/cnlf_ctrl.sv =====
// Control state machine of the caret notation line formatter.
module cnlf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_ready,
  input  cnlf_pkg::dp_status_t status,
  output cnlf_pkg::dp_cmd_t    cmd
);
  import cnlf_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (status.cmd == CMD_TEXT) begin
          if (status.at_limit) begin
            state_nxt = ST_IDLE;
          end else if (status.is_tab) begin
            state_nxt = ST_MOD;
          end else begin
            state_nxt = ST_EMIT;
          end
        end else if (status.cmd == CMD_END && status.list_mode) begin
          state_nxt = status.at_limit ? ST_COMMIT : ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MOD: begin
        if (status.mod_last) state_nxt = ST_TABN;
      end
      ST_TABN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready && status.out_last) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.load     = in_valid;
      end
      ST_DECODE: begin
        cmd.fmt        = 1'b1;
        cmd.set_cursor = (status.cmd == CMD_START);
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
      end
      ST_TABN: begin
        cmd.tab_n = 1'b1;
      end
      ST_EMIT: begin
        cmd.out_valid = 1'b1;
        cmd.emit_step = out_ready;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/cnlf_datapath.sv =====
// Datapath of the caret notation line formatter: settings, cursor, formatter and tab remainder.
module cnlf_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_wdata,
  input  logic [1:0]           in_cmd,
  input  logic [7:0]           in_char_code,
  input  logic [7:0]           in_start_col,
  input  cnlf_pkg::dp_cmd_t    cmd,
  output cnlf_pkg::dp_status_t status,
  output logic [7:0]           out_char,
  output logic [7:0]           out_col,
  output logic                 out_last
);
  import cnlf_pkg::*;

  logic [7:0] screen_cols_r;
  logic [4:0] tab_size_r;
  logic       list_mode_r;
  logic       raw_high_r;
  logic [7:0] cursor_r, cursor_nxt;

  logic [1:0] cmd_r;
  logic [7:0] char_r;
  logic [7:0] start_r;

  logic [7:0] c0_r, c1_r, c2_r;
  logic [7:0] c0_nxt, c1_nxt, c2_nxt;
  logic [4:0] n_r, n_nxt;
  logic [3:0] idx_r;

  logic [7:0] div_r;
  logic [4:0] rem_r, rem_nxt;
  logic [2:0] mcnt_r;
  logic [4:0] mod_t;

  logic [7:0] lim;
  logic [4:0] ts;
  logic [8:0] col9;
  logic [8:0] sum9;
  logic       is_tab;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_cols_r <= RST_SCREEN_COLS;
      tab_size_r    <= RST_TAB_SIZE;
      list_mode_r   <= 1'b0;
      raw_high_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_COLS: screen_cols_r <= cfg_wdata;
        REG_TAB_SIZE:    tab_size_r    <= cfg_wdata[4:0];
        REG_LIST_MODE:   list_mode_r   <= cfg_wdata[0];
        REG_RAW_HIGH:    raw_high_r    <= cfg_wdata[0];
        default:         screen_cols_r <= screen_cols_r;
      endcase
    end
  end

  assign lim    = (screen_cols_r > 8'(MAX_COLS)) ? 8'(MAX_COLS) : screen_cols_r;
  assign ts     = tab_eff(tab_size_r);
  assign is_tab = (cmd_r == CMD_TEXT) && (char_r == CH_TAB) && !list_mode_r;
  assign col9   = {1'b0, cursor_r} + {5'd0, idx_r};
  assign sum9   = {1'b0, cursor_r} + {4'd0, n_r};
  assign mod_t  = {rem_r[3:0], div_r[7]};

  always_comb begin
    cursor_nxt = cursor_r;
    if (cmd.set_cursor) begin
      cursor_nxt = start_r;
    end else if (cmd.commit) begin
      cursor_nxt = sum9[8] ? 8'hFF : sum9[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= 8'd0;
    end else begin
      cursor_r <= cursor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_cmd;
      char_r  <= in_char_code;
      start_r <= in_start_col;
    end
  end

  always_comb begin
    c0_nxt = CH_SPACE;
    c1_nxt = CH_SPACE;
    c2_nxt = CH_SPACE;
    n_nxt  = 5'd1;
    if (cmd_r == CMD_END) begin
      c0_nxt = CH_DOLLAR;
    end else if (char_r >= CH_SPACE && char_r < CH_DEL) begin
      c0_nxt = char_r;
    end else if (is_tab) begin
      n_nxt = 5'd1;
    end else if (!char_r[7]) begin
      c0_nxt = CH_CARET;
      c1_nxt = char_r ^ CARET_FLIP;
      n_nxt  = 5'd2;
    end else if (raw_high_r) begin
      c0_nxt = char_r;
    end else begin
      c0_nxt = CH_BACKSLASH;
      c1_nxt = hex_digit(char_r[7:4]);
      c2_nxt = hex_digit(char_r[3:0]);
      n_nxt  = 5'd3;
    end
  end

  always_comb begin
    rem_nxt = (mod_t >= ts) ? (mod_t - ts) : mod_t;
  end

  always_ff @(posedge clk) begin
    if (cmd.fmt) begin
      c0_r   <= c0_nxt;
      c1_r   <= c1_nxt;
      c2_r   <= c2_nxt;
      n_r    <= n_nxt;
      idx_r  <= 4'd0;
      div_r  <= cursor_r;
      rem_r  <= 5'd0;
      mcnt_r <= 3'd0;
    end else begin
      if (cmd.mod_step) begin
        rem_r  <= rem_nxt;
        div_r  <= {div_r[6:0], 1'b0};
        mcnt_r <= mcnt_r + 3'd1;
      end
      if (cmd.tab_n) begin
        n_r <= ts - rem_r;
      end
      if (cmd.emit_step) begin
        idx_r <= idx_r + 4'd1;
      end
    end
  end

  always_comb begin
    case (idx_r)
      4'd0:    out_char = c0_r;
      4'd1:    out_char = c1_r;
      4'd2:    out_char = c2_r;
      default: out_char = CH_SPACE;
    endcase
  end

  assign out_col  = col9[7:0];
  assign out_last = (({1'b0, idx_r} + 5'd1) == n_r) || ((col9 + 9'd1) >= {1'b0, lim});

  assign status.cmd       = cmd_r;
  assign status.is_tab    = is_tab;
  assign status.at_limit  = (cursor_r >= lim);
  assign status.list_mode = list_mode_r;
  assign status.mod_last  = (mcnt_r == 3'd7);
  assign status.out_last  = out_last;

endmodule

// ===== rtl/caret_notation_line_formatter.sv =====
// Top level of the caret notation line formatter: controller, datapath and checks.
// Takes one item at a time and writes one screen character per cycle while the result
// side is ready. A tab first finds its stop distance with a bit-serial remainder unit
// that handles one bit of the cursor column per cycle. Start-line, ignored and unused
// items go from decode straight back to idle; an end-of-line '$' past the column limit
// goes to commit without being emitted. Settings are written through the cfg port
// while no item is in flight; the user must keep to this, the block does not enforce it.
module caret_notation_line_formatter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  cnlf_in_if.sink    in_ch,
  cnlf_out_if.source out_ch
);
  import cnlf_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  cnlf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .status    (dp_status),
    .cmd       (dp_cmd)
  );

  cnlf_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_cmd       (in_ch.cmd),
    .in_char_code (in_ch.char_code),
    .in_start_col (in_ch.start_col),
    .cmd          (dp_cmd),
    .status       (dp_status),
    .out_char     (out_ch.out_char),
    .out_col      (out_ch.out_col),
    .out_last     (out_ch.last)
  );

  assign in_ch.ready  = dp_cmd.in_ready;
  assign out_ch.valid = dp_cmd.out_valid;

`ifndef NO_ASSERTIONS
  a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input ready while a result is pending");

  a_one_item_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready && !out_ch.valid)
    else $error("item accepted without decode cycle");

  a_columns_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last) |=>
      (out_ch.valid && (out_ch.out_col == $past(out_ch.out_col) + 8'd1)))
    else $error("result columns not consecutive within an item");
`endif

endmodule
